// File: rtl/core/kdr_pkg.sv
// ----------------------------------------------------------------------------
// kdr_pkg
// Shared widths, codes and types of the keypad debounce and repeat scanner.
// ----------------------------------------------------------------------------
package kdr_pkg;

    localparam int DEF_ROWS    = 4;
    localparam int DEF_COLUMNS = 4;
    localparam int KEY_MAX     = 16;

    localparam int KEY_W   = 4;
    localparam int LIM_W   = 8;
    localparam int MS_W    = 16;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 24;
    localparam int RAW_W   = 16;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE     = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_WAKE = 1'b1;

    localparam logic [LIM_W-1:0]  DEF_DEBOUNCE = 8'd5;
    localparam logic [MS_W-1:0]   DEF_DELAY    = 16'd500;
    localparam logic [MS_W-1:0]   DEF_PERIOD   = 16'd100;
    localparam logic [MS_W-1:0]   DEF_IDLE     = 16'd1000;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_REPEAT  = 2'd2,
        KIND_STATUS  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [LIM_W-1:0]  level;
        logic              stable;
        logic              set_change;
        logic              set_repeat;
        logic              act;
        logic              ev;
        kind_t             kind;
        logic [HOLD_W-1:0] hold;
        logic              ge_delay;
    } key_upd_t;

endpackage

// File: rtl/core/keypad_debounce_repeat_scanner.sv
// ----------------------------------------------------------------------------
// keypad_debounce_repeat_scanner
// Keypad scanner: per-key debounce integrator, press/release/repeat events,
// wake and idle stop; keys are walked one per cycle, while m_ is free, through a shared unit.
// A wake or idle tick goes to ST_STATUS, which registers its status beat.
// A scan tick walks the keys in ST_WALK, one key per cycle while results
// are taken (a stall on m_ holds the walk), then its status beat follows.
// Not ready while an item is in progress. Reset: not scanning, all key
// state cleared, registers back to their defaults.
// ----------------------------------------------------------------------------
module keypad_debounce_repeat_scanner
    import kdr_pkg::*;
#(
    parameter int ROWS    = DEF_ROWS,
    parameter int COLUMNS = DEF_COLUMNS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // raw_keys[15:0], now_ms[47:16]
    input  logic [0:0]            s_axis_tuser,   // cmd[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // key_code[3:0], hold_ms[27:4], event_time[59:28], scanning[60], any_held[61]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser,   // kind[1:0]
    output logic                  m_axis_tlast
);

    localparam int NKEYS = (ROWS * COLUMNS > KEY_MAX) ? KEY_MAX : ROWS * COLUMNS;
    localparam int KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam logic [KW-1:0] LAST_KEY = KW'(NKEYS - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_STATUS = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [LIM_W-1:0] debounce_reg;
    logic [MS_W-1:0]  delay_reg;
    logic [MS_W-1:0]  period_reg;
    logic [MS_W-1:0]  idle_reg;

    logic [LIM_W-1:0]  integ_reg  [NKEYS];
    logic [TIME_W-1:0] change_reg [NKEYS];
    logic [TIME_W-1:0] repeat_reg [NKEYS];
    logic [NKEYS-1:0]  stable_reg;
    logic [TIME_W-1:0] activity_reg;
    logic              scan_reg, scan_next;
    logic              walk_reg, walk_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [NKEYS-1:0]  raw_reg;
    logic [TIME_W-1:0] now_reg;

    logic              m_valid_reg, m_valid_next;
    kind_t             m_kind_reg, m_kind_next;
    logic [KEY_W-1:0]  m_code_reg, m_code_next;
    logic [HOLD_W-1:0] m_hold_reg, m_hold_next;
    logic [TIME_W-1:0] m_time_reg, m_time_next;
    logic              m_scan_reg, m_scan_next;
    logic              m_held_reg, m_held_next;
    logic              m_last_reg, m_last_next;

    logic              in_acc;
    logic              out_free;
    logic              walk_step;
    logic              is_status;
    logic              scan_stat;
    key_upd_t          upd;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign walk_step     = (state_reg == ST_WALK) && out_free;
    assign is_status     = (state_reg == ST_STATUS);

    kdr_key_unit u_key (
        .level          (integ_reg[key_reg]),
        .pressed        (raw_reg[key_reg]),
        .stable         (stable_reg[key_reg]),
        .change_time    (is_status ? activity_reg : change_reg[key_reg]),
        .repeat_time    (repeat_reg[key_reg]),
        .now_ms         (now_reg),
        .debounce_limit (debounce_reg),
        .age_limit      (is_status ? idle_reg : delay_reg),
        .period_ms      (period_reg),
        .upd            (upd)
    );

    assign scan_stat = scan_reg && !(walk_reg && !(|stable_reg) && upd.ge_delay);

    always_comb begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        walk_next    = walk_reg;
        key_next     = key_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_kind_next  = m_kind_reg;
        m_code_next  = m_code_reg;
        m_hold_next  = m_hold_reg;
        m_time_next  = m_time_reg;
        m_scan_next  = m_scan_reg;
        m_held_next  = m_held_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    key_next = '0;
                    if (s_axis_tuser[0] == CMD_WAKE) begin
                        scan_next  = 1'b1;
                        walk_next  = 1'b0;
                        state_next = ST_STATUS;
                    end else if (scan_reg) begin
                        walk_next  = 1'b1;
                        state_next = ST_WALK;
                    end else begin
                        walk_next  = 1'b0;
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    if (upd.ev) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = upd.kind;
                        m_code_next  = KEY_W'(key_reg);
                        m_hold_next  = (upd.kind == KIND_RELEASE) ? upd.hold : '0;
                        m_time_next  = now_reg;
                        m_scan_next  = 1'b0;
                        m_held_next  = 1'b0;
                        m_last_next  = 1'b0;
                    end
                    if (key_reg == LAST_KEY) begin
                        state_next = ST_STATUS;
                    end else begin
                        key_next = key_reg + KW'(1);
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    scan_next    = scan_stat;
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_STATUS;
                    m_code_next  = '0;
                    m_hold_next  = '0;
                    m_time_next  = now_reg;
                    m_scan_next  = scan_stat;
                    m_held_next  = |stable_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_reg     <= 1'b0;
            walk_reg     <= 1'b0;
            key_reg      <= '0;
            m_valid_reg  <= 1'b0;
            debounce_reg <= DEF_DEBOUNCE;
            delay_reg    <= DEF_DELAY;
            period_reg   <= DEF_PERIOD;
            idle_reg     <= DEF_IDLE;
        end else begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            walk_reg    <= walk_next;
            key_reg     <= key_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_DEBOUNCE: debounce_reg <= cfg_wdata[LIM_W-1:0];
                    CFG_DELAY:    delay_reg    <= cfg_wdata[MS_W-1:0];
                    CFG_PERIOD:   period_reg   <= cfg_wdata[MS_W-1:0];
                    CFG_IDLE:     idle_reg     <= cfg_wdata[MS_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg   <= '0;
            activity_reg <= '0;
            for (int i = 0; i < NKEYS; i++) begin
                integ_reg[i]  <= '0;
                change_reg[i] <= '0;
                repeat_reg[i] <= '0;
            end
        end else if (walk_step) begin
            integ_reg[key_reg]  <= upd.level;
            stable_reg[key_reg] <= upd.stable;
            if (upd.set_change) begin
                change_reg[key_reg] <= now_reg;
            end
            if (upd.set_repeat) begin
                repeat_reg[key_reg] <= now_reg;
            end
            if (upd.act) begin
                activity_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            raw_reg <= s_axis_tdata[NKEYS-1:0];
            now_reg <= s_axis_tdata[RAW_W +: TIME_W];
        end
        m_kind_reg <= m_kind_next;
        m_code_reg <= m_code_next;
        m_hold_reg <= m_hold_next;
        m_time_reg <= m_time_next;
        m_scan_reg <= m_scan_next;
        m_held_reg <= m_held_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {2'b00, m_held_reg, m_scan_reg, m_time_reg, m_hold_reg, m_code_reg};

endmodule

// File: rtl/core/kdr_key_unit.sv
// ----------------------------------------------------------------------------
// kdr_key_unit
// Shared update unit: integrator step, event decision and elapsed-time compare
// for one key, also reused for the idle timeout check.
// ----------------------------------------------------------------------------
module kdr_key_unit
    import kdr_pkg::*;
(
    input  logic [LIM_W-1:0]  level,
    input  logic              pressed,
    input  logic              stable,
    input  logic [TIME_W-1:0] change_time,
    input  logic [TIME_W-1:0] repeat_time,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [LIM_W-1:0]  debounce_limit,
    input  logic [MS_W-1:0]   age_limit,
    input  logic [MS_W-1:0]   period_ms,
    output key_upd_t          upd
);

    logic [LIM_W-1:0]  top;
    logic [LIM_W-1:0]  vc;
    logic [TIME_W-1:0] d_change;
    logic [TIME_W-1:0] d_repeat;
    logic              ge_period;

    assign top       = (debounce_limit == '0) ? LIM_W'(1) : debounce_limit;
    assign vc        = (level > top) ? top : level;
    assign d_change  = now_ms - change_time;
    assign d_repeat  = now_ms - repeat_time;
    assign ge_period = d_repeat >= TIME_W'(period_ms);

    always_comb begin
        upd            = '0;
        upd.level      = vc;
        upd.stable     = stable;
        upd.kind       = KIND_PRESS;
        upd.ge_delay   = d_change >= TIME_W'(age_limit);
        upd.hold       = (d_change[TIME_W-1:HOLD_W] != '0) ? '1 : d_change[HOLD_W-1:0];
        if (vc != '0 && vc != top) begin
            upd.level = pressed ? vc + LIM_W'(1) : vc - LIM_W'(1);
        end else if (vc == '0) begin
            if (pressed) begin
                upd.level = LIM_W'(1);
                upd.act   = 1'b1;
            end else if (stable) begin
                upd.ev         = 1'b1;
                upd.kind       = KIND_RELEASE;
                upd.set_change = 1'b1;
                upd.stable     = 1'b0;
                upd.act        = 1'b1;
            end
        end else begin
            if (!pressed) begin
                upd.level = vc - LIM_W'(1);
                upd.act   = 1'b1;
            end else if (!stable) begin
                upd.ev         = 1'b1;
                upd.kind       = KIND_PRESS;
                upd.set_change = 1'b1;
                upd.set_repeat = 1'b1;
                upd.stable     = 1'b1;
                upd.act        = 1'b1;
            end else if (upd.ge_delay && ge_period) begin
                upd.ev         = 1'b1;
                upd.kind       = KIND_REPEAT;
                upd.set_repeat = 1'b1;
                upd.act        = 1'b1;
            end
        end
    end

endmodule

// File: tb/tb_keypad_debounce_repeat_scanner.sv
// ----------------------------------------------------------------------------
// tb_keypad_debounce_repeat_scanner
// Self-checking bench for the keypad scanner. A scoreboard class mirrors the
// per-key integrators and the press, release and repeat timing. It also
// mirrors wake and idle stop, and queues the beats that each item must
// produce. A short directed run covers full-pad press, repeat, release with
// and without hold saturation, time wrap and idle stop. Random phases
// follow, with new register settings per phase. They send held key patterns
// with bounce noise, time jumps and wakes, while both stream sides stall at
// random.
// ----------------------------------------------------------------------------
module tb_keypad_debounce_repeat_scanner
    import kdr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                CLK_PERIOD     = 20;
    localparam int                NUM_KEYS       = DEF_ROWS * DEF_COLUMNS;
    localparam logic [TIME_W-1:0] HOLD_SAT       = 32'h00FF_FFFF;
    localparam int                SETTLE_CYCLES  = 24;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                PHASE_ITEMS    = 58;
    localparam int                NUM_PHASES     = 6;

    typedef struct packed {
        kind_t             kind;
        logic [KEY_W-1:0]  key_code;
        logic [HOLD_W-1:0] hold_ms;
        logic [TIME_W-1:0] event_time;
        logic              scanning;
        logic              any_held;
        logic              last;
    } key_event_t;

    class keypad_scoreboard;
        logic [LIM_W-1:0]  debounce_limit;
        logic [MS_W-1:0]   repeat_delay;
        logic [MS_W-1:0]   repeat_period;
        logic [MS_W-1:0]   idle_timeout;
        logic [LIM_W-1:0]  level [NUM_KEYS];
        logic              pressed [NUM_KEYS];
        logic [TIME_W-1:0] changed_at [NUM_KEYS];
        logic [TIME_W-1:0] repeated_at [NUM_KEYS];
        logic [TIME_W-1:0] activity_at;
        logic              scan_on;
        key_event_t        pending_events [$];
        int                errors;

        function new();
            debounce_limit = DEF_DEBOUNCE;
            repeat_delay   = DEF_DELAY;
            repeat_period  = DEF_PERIOD;
            idle_timeout   = DEF_IDLE;
            for (int k = 0; k < NUM_KEYS; k++) begin
                level[k]       = '0;
                pressed[k]     = 1'b0;
                changed_at[k]  = '0;
                repeated_at[k] = '0;
            end
            activity_at = '0;
            scan_on     = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DEBOUNCE: debounce_limit = val[LIM_W-1:0];
                CFG_DELAY:    repeat_delay   = val[MS_W-1:0];
                CFG_PERIOD:   repeat_period  = val[MS_W-1:0];
                CFG_IDLE:     idle_timeout   = val[MS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic some_key_held();
            for (int k = 0; k < NUM_KEYS; k++)
                if (pressed[k])
                    return 1'b1;
            return 1'b0;
        endfunction

        function void push_event(kind_t kind, int key, logic [HOLD_W-1:0] hold,
                                 logic [TIME_W-1:0] stamp, logic scanning,
                                 logic held, logic last);
            key_event_t ev;
            ev.kind       = kind;
            ev.key_code   = key[KEY_W-1:0];
            ev.hold_ms    = hold;
            ev.event_time = stamp;
            ev.scanning   = scanning;
            ev.any_held   = held;
            ev.last       = last;
            pending_events.push_back(ev);
        endfunction

        function void scan_item(logic cmd, logic [RAW_W-1:0] raw, logic [TIME_W-1:0] stamp);
            logic [LIM_W-1:0]  top;
            logic [LIM_W-1:0]  v;
            logic [TIME_W-1:0] since_change;
            logic [TIME_W-1:0] since_repeat;
            logic              p;
            if (cmd == CMD_WAKE) begin
                scan_on = 1'b1;
            end else if (scan_on) begin
                top = (debounce_limit == '0) ? 8'd1 : debounce_limit;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    p = raw[k];
                    v = (level[k] > top) ? top : level[k];
                    since_change = stamp - changed_at[k];
                    since_repeat = stamp - repeated_at[k];
                    if (v > 0 && v < top) begin
                        v = p ? v + 8'd1 : v - 8'd1;
                    end else if (v == 0) begin
                        if (p) begin
                            v = 8'd1;
                            activity_at = stamp;
                        end else if (pressed[k]) begin
                            if (since_change > HOLD_SAT)
                                since_change = HOLD_SAT;
                            push_event(KIND_RELEASE, k, since_change[HOLD_W-1:0], stamp,
                                       1'b0, 1'b0, 1'b0);
                            changed_at[k] = stamp;
                            pressed[k]    = 1'b0;
                            activity_at   = stamp;
                        end
                    end else begin
                        if (!p) begin
                            v = v - 8'd1;
                            activity_at = stamp;
                        end else if (!pressed[k]) begin
                            push_event(KIND_PRESS, k, '0, stamp, 1'b0, 1'b0, 1'b0);
                            changed_at[k]  = stamp;
                            repeated_at[k] = stamp;
                            pressed[k]     = 1'b1;
                            activity_at    = stamp;
                        end else if (since_change >= {16'd0, repeat_delay} &&
                                     since_repeat >= {16'd0, repeat_period}) begin
                            push_event(KIND_REPEAT, k, '0, stamp, 1'b0, 1'b0, 1'b0);
                            repeated_at[k] = stamp;
                            activity_at    = stamp;
                        end
                    end
                    level[k] = v;
                end
                since_change = stamp - activity_at;
                if (!some_key_held() && since_change >= {16'd0, idle_timeout})
                    scan_on = 1'b0;
            end
            push_event(KIND_STATUS, 0, '0, stamp, scan_on, some_key_held(), 1'b1);
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (want_v !== got_v) begin
                $error("%s: expected %0d, actual %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_event(kind_t kind, logic [OUT_DATA_W-1:0] data, logic last);
            key_event_t want;
            if (pending_events.size() == 0) begin
                $error("unexpected beat: kind %0d key %0d", kind, data[3:0]);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("kind", want.kind, kind);
            compare_field("key_code", want.key_code, data[3:0]);
            compare_field("hold_ms", want.hold_ms, data[27:4]);
            compare_field("event_time", want.event_time, data[59:28]);
            compare_field("scanning", want.scanning, data[60]);
            compare_field("any_held", want.any_held, data[61]);
            compare_field("last", want.last, last);
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // raw_keys[15:0], now_ms[47:16]
    logic [0:0]            s_axis_tuser  = '0;   // cmd[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // key_code[3:0], hold_ms[27:4], event_time[59:28], scanning[60], any_held[61]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;         // kind[1:0]
    logic                  m_axis_tlast;

    keypad_scoreboard      board;
    logic [TIME_W-1:0]     now_ms;
    logic [RAW_W-1:0]      held_keys;
    int                    quiet_cycles = 0;

    keypad_debounce_repeat_scanner i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin : ready_driver
        int run;
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            run   = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
            stall = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            m_axis_tready <= 1'b0;
            repeat (stall) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_event(kind_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** keypad_debounce_repeat_scanner: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [RAW_W-1:0] raw,
                             input logic [TIME_W-1:0] stamp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {stamp, raw};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.scan_item(cmd, raw, stamp);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] dly,
                                input logic [CFG_DATA_W-1:0] per, input logic [CFG_DATA_W-1:0] idl);
        write_reg(CFG_DEBOUNCE, lim);
        write_reg(CFG_DELAY, dly);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_IDLE, idl);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        int               r;
        logic             cmd;
        logic [RAW_W-1:0] raw;
        if ($urandom_range(0, 24) == 0)
            held_keys = ($urandom_range(0, 2) == 0) ? RAW_W'($urandom)
                                                    : RAW_W'($urandom & $urandom & $urandom);
        r = $urandom_range(0, 99);
        if (r < 3)
            now_ms = $urandom;
        else if (r < 7)
            now_ms = now_ms + $urandom_range(0, 2000);
        else
            now_ms = now_ms + $urandom_range(0, 3);
        raw = held_keys;
        r = $urandom_range(0, 99);
        if (r < 5)
            raw = RAW_W'($urandom);
        else if (r < 30)
            raw[$urandom_range(0, RAW_W - 1)] = ~raw[$urandom_range(0, RAW_W - 1)];
        cmd = ($urandom_range(0, 16) == 0) ? CMD_WAKE : CMD_TICK;
        if ($urandom_range(0, 49) == 0)
            drain();
        send_item(cmd, raw, now_ms);
    endtask

    initial begin : main
        logic [TIME_W-1:0] t;
        board     = new();
        held_keys = '0;
        now_ms    = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(CMD_TICK, 16'hFFFF, 32'd0);
        send_item(CMD_WAKE, 16'h0000, 32'd0);
        send_item(CMD_WAKE, 16'hFFFF, 32'd1);
        t = 32'hFFFF_FFFC;
        repeat (5) begin
            send_item(CMD_TICK, 16'hFFFF, t);
            t = t + 1;
        end
        t = t + 499;
        send_item(CMD_TICK, 16'hFFFF, t);
        t = t + 50;
        send_item(CMD_TICK, 16'hFFFF, t);
        t = t + 100;
        send_item(CMD_TICK, 16'hFFFF, t);
        repeat (6) begin
            t = t + 1;
            send_item(CMD_TICK, 16'h00FF, t);
        end
        t = t + 32'h0200_0000;
        repeat (6) begin
            send_item(CMD_TICK, 16'h0000, t);
            t = t + 1;
        end
        t = t + 1000;
        send_item(CMD_TICK, 16'h0000, t);
        send_item(CMD_TICK, 16'h5555, t + 1);
        now_ms = t + 2;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: program_regs(16'd1, 16'd0, 16'd1, 16'd0);
                1: program_regs(16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: program_regs(16'd0, 16'd3, 16'd0, 16'd20);
                3: program_regs(16'hFF03, 16'($urandom_range(0, 12)),
                                16'($urandom_range(1, 6)), 16'($urandom_range(0, 40)));
                default: program_regs(16'($urandom_range(1, 4)), 16'($urandom_range(0, 12)),
                                      16'($urandom_range(0, 6)), 16'($urandom_range(0, 40)));
            endcase
            send_item(CMD_WAKE, RAW_W'($urandom), now_ms);
            repeat (PHASE_ITEMS) random_item();
        end

        drain();
        if (board.errors == 0 && board.pending_events.size() == 0)
            $display("** keypad_debounce_repeat_scanner: PASSED **");
        else
            $display("** keypad_debounce_repeat_scanner: FAILED **");
        $finish;
    end

endmodule
